[design/ipv4fr_pkg.sv]
// Shared types, constants and status codes for the IPv4 fragment reassembly tracker.
package ipv4fr_pkg;

   localparam int ENTRIES      = 4;
   localparam int BUFFER_BYTES = 8192;
   localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [15:0] HDR_BYTES = 16'd20;
   localparam logic [3:0]  IP_VERSION = 4'd4;
   localparam logic [3:0]  IHL_WORDS  = 4'd5;

   typedef enum logic [2:0] {
      ST_BAD_HEADER   = 3'd0,
      ST_BAD_LENGTH   = 3'd1,
      ST_UNFRAGMENTED = 3'd2,
      ST_WAITING      = 3'd3,
      ST_COMPLETE     = 3'd4,
      ST_NO_ENTRY     = 3'd5,
      ST_OVERFLOW     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SCAN,
      PH_HOLD
   } phase_type;

   // Search key passed along the cell chain
   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] ident;
   } key_type;

   // Match and free-entry result handed from cell to cell
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic             free;
      logic [IDX_W-1:0] free_idx;
   } scan_type;

   // Update command broadcast by the controller to every cell
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             fresh;
      logic             set_last;
      logic [15:0]      total;
      logic [15:0]      clen;
      logic             release_entry;
   } upd_type;

   // Entry contents of the selected cell
   typedef struct packed {
      logic        last;
      logic [15:0] bytes;
      logic [15:0] total;
   } entry_type;

endpackage

[design/ipv4fr_cell.sv]
// One reassembly entry: key, byte count and total, plus its step of the match chain.
module ipv4fr_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ipv4fr_pkg::IDX_W-1:0] my_idx,
   input  ipv4fr_pkg::key_type         key,
   input  ipv4fr_pkg::scan_type        scan_prev,
   output ipv4fr_pkg::scan_type        scan_next,
   input  ipv4fr_pkg::upd_type         upd,
   output ipv4fr_pkg::entry_type       entry
);
   import ipv4fr_pkg::*;

   logic        valid_ff, valid_in;
   logic        last_ff, last_in;
   key_type     key_ff;
   logic [15:0] bytes_ff;
   logic [15:0] total_ff;
   logic        sel;
   logic [16:0] sum;
   logic [15:0] bytes_new;
   logic        match;

   // Match against stored key; lowest index wins for both hit and free
   assign match = valid_ff && (key_ff == key);
   always_comb begin
      scan_next = scan_prev;
      if (!scan_prev.hit && match) begin
         scan_next.hit     = 1'b1;
         scan_next.hit_idx = my_idx;
      end
      if (!scan_prev.free && !valid_ff) begin
         scan_next.free     = 1'b1;
         scan_next.free_idx = my_idx;
      end
   end

   assign sel = upd.en && (upd.idx == my_idx);
   assign sum = {1'b0, (upd.fresh ? 16'd0 : bytes_ff)} + {1'b0, upd.clen};
   assign bytes_new = sum[16] ? 16'hFFFF : sum[15:0];

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      if (sel) begin
         valid_in = !upd.release_entry;
         last_in  = upd.release_entry ? 1'b0 : (upd.set_last | (last_ff & !upd.fresh));
      end
   end

   // Hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   // Latch key, count and total on update
   always_ff @(posedge clock) begin
      if (sel) begin
         if (upd.fresh) key_ff <= key;
         if (upd.set_last) total_ff <= upd.total;
         bytes_ff <= bytes_new;
      end
   end

   assign entry.last  = last_ff;
   assign entry.bytes = bytes_ff;
   assign entry.total = total_ff;

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      sel && upd.release_entry |=> !valid_ff && !last_ff)
      else $error("released entry still valid");
   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      last_ff |-> valid_ff)
      else $error("last flag on free entry");
   a_fresh_only_free: assert property (@(posedge clock) disable iff (reset)
      sel && upd.fresh |-> !valid_ff)
      else $error("allocation of busy entry");
endmodule

[design/ipv4_fragment_reassembly_tracker.sv]
// Top level: header check, cell chain of reassembly entries and result register.
// The header is checked and registered on accept; the scan and the entry update run
//   in the scan phase, and the result register is loaded at its end.
// A new header is taken only in the idle phase, after the accept, scan and hold steps
//   of the last one; the entry update is a read-modify-write of the chosen cell.
// Result beats wait in an output register; a new header is taken once it clears.
// Reset: synchronous, active high; all entries free, no result pending.
module ipv4_fragment_reassembly_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_version,
   input  logic [3:0]  req_header_words,
   input  logic [15:0] req_total_length,
   input  logic [15:0] req_captured_length,
   input  logic        req_more_fragments,
   input  logic [12:0] req_frag_offset_units,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_ident,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [1:0]  rsp_entry_index,
   output logic [15:0] rsp_buf_offset,
   output logic [15:0] rsp_copy_length,
   output logic [15:0] rsp_datagram_length
);
   import ipv4fr_pkg::*;

   phase_type   phase_ff, phase_in;
   key_type     key_ff;
   logic        mf_ff;
   logic        early_ff;
   status_type  early_st_ff;
   logic [15:0] tlen_ff;
   logic [15:0] coff_ff;
   logic [15:0] clen_ff;
   logic [16:0] end_ff;

   scan_type    chain [ENTRIES+1];
   upd_type     upd;
   entry_type   ents [ENTRIES];

   logic        found;
   logic [IDX_W-1:0] idx;
   logic        fresh;
   logic        ovf;
   logic [16:0] sum;
   logic [15:0] bytes_new;
   logic        last_now;
   logic [15:0] total_now;
   logic        done;
   logic        accept;

   status_type  st_out_ff;
   logic [1:0]  idx_out_ff;
   logic [15:0] coff_out_ff, clen_out_ff, dlen_out_ff;
   logic        rsp_valid_ff;

   logic [15:0] offs;
   logic        bad_hdr, bad_len, unfrag;

   assign req_ready = (phase_ff == PH_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Header checks and copy placement
   assign offs    = {req_frag_offset_units, 3'b000};
   assign bad_hdr = (req_captured_length < HDR_BYTES) || (req_version != IP_VERSION)
                    || (req_header_words != IHL_WORDS);
   assign bad_len = (req_total_length < HDR_BYTES) || (req_total_length > req_captured_length);
   assign unfrag  = !req_more_fragments && (offs == 16'd0);

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= '{src: req_src_addr, dst: req_dst_addr, ident: req_ident};
         mf_ff   <= req_more_fragments;
         tlen_ff <= req_total_length;
         early_ff <= bad_hdr || bad_len || unfrag;
         priority if (bad_hdr) early_st_ff <= ST_BAD_HEADER;
         else if (bad_len)     early_st_ff <= ST_BAD_LENGTH;
         else                  early_st_ff <= ST_UNFRAGMENTED;
         if (offs == 16'd0) begin
            coff_ff <= 16'd0;
            clen_ff <= req_total_length;
            end_ff  <= {1'b0, req_total_length};
         end else begin
            coff_ff <= offs + HDR_BYTES;
            clen_ff <= req_total_length - HDR_BYTES;
            end_ff  <= {1'b0, offs} + {1'b0, req_total_length};
         end
      end
   end

   // Cell chain
   assign chain[0] = '0;
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      ipv4fr_cell u_cell (
         .clock(clock), .reset(reset),
         .my_idx(IDX_W'(g)),
         .key(key_ff),
         .scan_prev(chain[g]),
         .scan_next(chain[g+1]),
         .upd(upd),
         .entry(ents[g])
      );
   end

   assign found = chain[ENTRIES].hit || chain[ENTRIES].free;
   assign fresh = !chain[ENTRIES].hit;
   assign idx   = chain[ENTRIES].hit ? chain[ENTRIES].hit_idx : chain[ENTRIES].free_idx;
   assign ovf   = end_ff > 17'(BUFFER_BYTES);

   assign sum       = {1'b0, (fresh ? 16'd0 : ents[idx].bytes)} + {1'b0, clen_ff};
   assign bytes_new = sum[16] ? 16'hFFFF : sum[15:0];
   assign last_now  = !mf_ff || (!fresh && ents[idx].last);
   assign total_now = !mf_ff ? end_ff[15:0] : ents[idx].total;
   assign done      = last_now && (bytes_new >= total_now);

   always_comb begin
      upd.en            = (phase_ff == PH_SCAN) && !early_ff && found && !ovf;
      upd.idx           = idx;
      upd.fresh         = fresh;
      upd.set_last      = !mf_ff;
      upd.total         = end_ff[15:0];
      upd.clen          = clen_ff;
      upd.release_entry = done;
   end

   // Phase sequencing
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: if (accept) phase_in = PH_SCAN;
         PH_SCAN: phase_in = PH_HOLD;
         PH_HOLD: phase_in = PH_IDLE;
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (phase_ff == PH_SCAN)   rsp_valid_ff <= 1'b1;
         else if (rsp_ready)        rsp_valid_ff <= 1'b0;
      end
   end

   // Build the result beat
   always_ff @(posedge clock) begin
      if (phase_ff == PH_SCAN) begin
         idx_out_ff  <= 2'd0;
         coff_out_ff <= 16'd0;
         clen_out_ff <= 16'd0;
         dlen_out_ff <= 16'd0;
         priority if (early_ff) begin
            st_out_ff <= early_st_ff;
            if (early_st_ff == ST_UNFRAGMENTED) dlen_out_ff <= tlen_ff;
         end else if (!found) begin
            st_out_ff <= ST_NO_ENTRY;
         end else begin
            idx_out_ff  <= 2'(idx);
            coff_out_ff <= coff_ff;
            clen_out_ff <= clen_ff;
            if (ovf) st_out_ff <= ST_OVERFLOW;
            else if (done) begin
               st_out_ff   <= ST_COMPLETE;
               dlen_out_ff <= total_now;
            end else st_out_ff <= ST_WAITING;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = st_out_ff;
   assign rsp_entry_index     = idx_out_ff;
   assign rsp_buf_offset      = coff_out_ff;
   assign rsp_copy_length     = clen_out_ff;
   assign rsp_datagram_length = dlen_out_ff;

   a_scan_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> phase_ff == PH_SCAN)
      else $error("accept did not start scan");
   a_result_after_scan: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SCAN |=> rsp_valid)
      else $error("scan gave no result");
   a_no_update_early: assert property (@(posedge clock) disable iff (reset)
      upd.en |-> !early_ff && !ovf)
      else $error("update on rejected header");
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the IPv4 fragment reassembly tracker.
`timescale 1ns / 100ps

module tb_top;
   import ipv4fr_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 1900;

   typedef struct packed {
      logic [3:0]  version;
      logic [3:0]  header_words;
      logic [15:0] total_length;
      logic [15:0] captured_length;
      logic        more_fragments;
      logic [12:0] frag_offset_units;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] ident;
   } header_beat_type;

   typedef struct packed {
      status_type  status;
      logic [1:0]  entry_index;
      logic [15:0] buf_offset;
      logic [15:0] copy_length;
      logic [15:0] datagram_length;
   } track_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0]  req_version = '0;
   logic [3:0]  req_header_words = '0;
   logic [15:0] req_total_length = '0;
   logic [15:0] req_captured_length = '0;
   logic        req_more_fragments = 1'b0;
   logic [12:0] req_frag_offset_units = '0;
   logic [31:0] req_src_addr = '0;
   logic [31:0] req_dst_addr = '0;
   logic [15:0] req_ident = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [1:0]  rsp_entry_index;
   logic [15:0] rsp_buf_offset;
   logic [15:0] rsp_copy_length;
   logic [15:0] rsp_datagram_length;

   ipv4_fragment_reassembly_tracker dut (.*);

   always #5 clock = ~clock;

   // Predictor state: reassembly table
   logic        tbl_valid [ENTRIES];
   logic        tbl_last  [ENTRIES];
   logic [31:0] tbl_src   [ENTRIES];
   logic [31:0] tbl_dst   [ENTRIES];
   logic [15:0] tbl_id    [ENTRIES];
   logic [15:0] tbl_bytes [ENTRIES];
   logic [15:0] tbl_total [ENTRIES];

   header_beat_type  pending_headers[$];
   track_result_type expected_results[$];
   int  idle_pct_send = 0;
   int  idle_pct_recv = 0;
   bit  hold_request = 1'b0;
   bit  hold_taken = 1'b0;
   int  hold_off = 0;
   int  mismatches = 0;
   int  watchdog = 0;
   bit  stim_done = 1'b0;

   function automatic track_result_type track_header(header_beat_type h);
      track_result_type r;
      int idx;
      bit fresh;
      int unsigned offs, coff, clen, sum;
      r = '{ST_BAD_HEADER, 2'd0, 16'd0, 16'd0, 16'd0};
      offs = h.frag_offset_units * 8;
      idx = -1;
      fresh = 1'b0;
      if (h.captured_length < 20 || h.version != IP_VERSION || h.header_words != IHL_WORDS)
         return r;
      if (h.total_length < 20 || h.total_length > h.captured_length) begin
         r.status = ST_BAD_LENGTH;
         return r;
      end
      if (!h.more_fragments && offs == 0) begin
         r.status = ST_UNFRAGMENTED;
         r.datagram_length = h.total_length;
         return r;
      end
      // Match on key, else take lowest free entry
      for (int i = 0; i < ENTRIES; i++)
         if (idx < 0 && tbl_valid[i] && tbl_src[i] == h.src_addr &&
             tbl_dst[i] == h.dst_addr && tbl_id[i] == h.ident)
            idx = i;
      if (idx < 0) begin
         fresh = 1'b1;
         for (int i = 0; i < ENTRIES; i++)
            if (idx < 0 && !tbl_valid[i]) idx = i;
      end
      if (idx < 0) begin
         r.status = ST_NO_ENTRY;
         return r;
      end
      if (offs == 0) begin
         coff = 0;
         clen = h.total_length;
      end else begin
         coff = offs + 20;
         clen = h.total_length - 20;
      end
      r.entry_index = idx[1:0];
      r.buf_offset  = coff[15:0];
      r.copy_length = clen[15:0];
      if (coff + clen > BUFFER_BYTES) begin
         r.status = ST_OVERFLOW;
         return r;
      end
      if (fresh) begin
         tbl_valid[idx] = 1'b1;
         tbl_last[idx]  = 1'b0;
         tbl_src[idx]   = h.src_addr;
         tbl_dst[idx]   = h.dst_addr;
         tbl_id[idx]    = h.ident;
         tbl_bytes[idx] = 16'd0;
      end
      if (!h.more_fragments) begin
         tbl_last[idx]  = 1'b1;
         tbl_total[idx] = 16'(coff + clen);
      end
      sum = tbl_bytes[idx] + clen;
      tbl_bytes[idx] = (sum > 65535) ? 16'hFFFF : sum[15:0];
      if (tbl_last[idx] && tbl_bytes[idx] >= tbl_total[idx]) begin
         r.status = ST_COMPLETE;
         r.datagram_length = tbl_total[idx];
         tbl_valid[idx] = 1'b0;
         tbl_last[idx]  = 1'b0;
      end else begin
         r.status = ST_WAITING;
      end
      return r;
   endfunction

   function automatic header_beat_type make_header(bit mf, int unsigned units,
                                                   int unsigned tlen, int unsigned flow);
      header_beat_type h;
      h.version = IP_VERSION;
      h.header_words = IHL_WORDS;
      h.total_length = tlen[15:0];
      h.captured_length = 16'(tlen + $urandom_range(0, 3) * $urandom_range(0, 1));
      if (h.captured_length < h.total_length) h.captured_length = 16'hFFFF;
      h.more_fragments = mf;
      h.frag_offset_units = units[12:0];
      h.src_addr = 32'hC0A8_0000 | flow[2:0];
      h.dst_addr = 32'h0A00_0001;
      h.ident = 16'h1000 + flow[15:0];
      return h;
   endfunction

   // Driver: present pending headers, hold payload until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(track_header({req_version, req_header_words,
               req_total_length, req_captured_length, req_more_fragments,
               req_frag_offset_units, req_src_addr, req_dst_addr, req_ident}));
         end
         if (!req_valid || req_ready) begin
            if (pending_headers.size() > 0 && $urandom_range(0, 99) >= idle_pct_send) begin
               header_beat_type h;
               h = pending_headers.pop_front();
               req_valid <= 1'b1;
               {req_version, req_header_words, req_total_length, req_captured_length,
                req_more_fragments, req_frag_offset_units, req_src_addr, req_dst_addr,
                req_ident} <= h;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat status=%0d", rsp_status);
            end else begin
               track_result_type e;
               e = expected_results.pop_front();
               if (rsp_status !== e.status || rsp_entry_index !== e.entry_index ||
                   rsp_buf_offset !== e.buf_offset || rsp_copy_length !== e.copy_length ||
                   rsp_datagram_length !== e.datagram_length) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch exp st=%0d idx=%0d off=%0d len=%0d dl=%0d",
                               " got st=%0d idx=%0d off=%0d len=%0d dl=%0d"},
                        e.status, e.entry_index, e.buf_offset, e.copy_length,
                        e.datagram_length, rsp_status, rsp_entry_index, rsp_buf_offset,
                        rsp_copy_length, rsp_datagram_length);
               end
            end
         end
      end
   end

   // Receiver: long hold-off counted here, otherwise random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_off   <= 300;
            rsp_ready  <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off  <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct_recv);
         end
      end
   end

   // Watchdog: count cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic drain_queue();
      while (pending_headers.size() > 0 || req_valid) @(posedge clock);
   endtask

   // Directed: extremes, every status, out-of-order last fragment
   task automatic load_directed();
      header_beat_type h;
      h = make_header(1'b0, 0, 20, 0); h.captured_length = 16'd19;
      pending_headers.push_back(h);
      h = make_header(1'b0, 0, 20, 0); h.version = 4'hF; pending_headers.push_back(h);
      h = make_header(1'b0, 0, 20, 0); h.header_words = 4'hF; pending_headers.push_back(h);
      h = make_header(1'b0, 0, 20, 0); h.version = 4'h0; h.header_words = 4'h0;
      pending_headers.push_back(h);
      h = make_header(1'b0, 0, 19, 0); h.captured_length = 16'hFFFF;
      pending_headers.push_back(h);
      h = make_header(1'b0, 0, 100, 0); h.captured_length = 16'd99;
      pending_headers.push_back(h);
      h = make_header(1'b0, 0, 65535, 0); h.captured_length = 16'hFFFF;
      h.src_addr = '1; h.dst_addr = '1; h.ident = '1; pending_headers.push_back(h);
      // last fragment arrives first, then the first
      pending_headers.push_back(make_header(1'b0, 10, 120, 1));
      pending_headers.push_back(make_header(1'b1, 0, 100, 1));
      // fill table, then table full
      for (int f = 2; f < 7; f++) pending_headers.push_back(make_header(1'b1, 0, 60, f));
      // overflow on a known entry and on max offset
      pending_headers.push_back(make_header(1'b1, 1000, 1500, 2));
      h = make_header(1'b1, 8191, 65535, 3); h.captured_length = 16'hFFFF;
      pending_headers.push_back(h);
      // complete the open entries
      for (int f = 2; f < 6; f++) pending_headers.push_back(make_header(1'b0, 5, 60, f));
      h = make_header(1'b1, 0, 20, 0); h.src_addr = '0; h.dst_addr = '0; h.ident = '0;
      pending_headers.push_back(h);
      h.more_fragments = 1'b0; h.frag_offset_units = 13'd0;
      h.frag_offset_units = 13'd1; pending_headers.push_back(h);
   endtask

   // Random: mostly well-formed fragment trains over a few flows, plus noise
   task automatic load_random(int count);
      header_beat_type h;
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 99) < 75) begin
            int unsigned flow, frags, chunk, pos;
            flow = $urandom_range(0, 7);
            frags = $urandom_range(1, 4);
            chunk = $urandom_range(1, 40);
            pos = 0;
            for (int k = 0; k < frags; k++) begin
               bit mf;
               mf = (k != frags - 1) || ($urandom_range(0, 9) == 0);
               if (pos == 0) h = make_header(mf, 0, chunk * 8 + 20, flow);
               else h = make_header(mf, pos, chunk * 8 + 20, flow);
               if ($urandom_range(0, 3) == 0) pending_headers.push_front(h);
               else pending_headers.push_back(h);
               pos += (pos == 0) ? chunk + 2 : chunk;
               n++;
            end
         end else begin
            h = header_beat_type'(134'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            if ($urandom_range(0, 1)) begin
               h.version = IP_VERSION;
               h.header_words = IHL_WORDS;
            end
            if ($urandom_range(0, 1)) h.src_addr[31:3] = 29'h18150000;
            pending_headers.push_back(h);
            n++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_last[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      load_directed();
      drain_queue();
      // Phases of idling: none, sender, receiver, both
      for (int p = 0; p < 4; p++) begin
         idle_pct_send = (p == 1) ? 45 : (p == 3) ? 28 : 0;
         idle_pct_recv = (p == 2) ? 45 : (p == 3) ? 28 : 0;
         if (p == 2) hold_request = 1'b1;
         load_random(RANDOM_ITEMS / 4);
         drain_queue();
      end
      while (expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
